@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared checks for the name classifier, clocked on clock
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is masked while reset is high
`define RDNC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that is also evaluated across reset
`define RDNC_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/rdnc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdnc_pkg
// types, device codes, name pattern list and vendor prefix list for the
// radio device name classifier
// ----------------------------------------------------------------------------
`default_nettype none

package rdnc_pkg;

   // window and table sizes
   localparam int WINDOW_LEN      = 14;
   localparam int PREFIX_ENTRIES  = 36;
   localparam int NUM_CATS        = 11;
   localparam int NUM_PATS        = 77;
   localparam int NUM_PREFIX_ROWS = 36;
   localparam int PAT_CHARS       = 14;
   localparam int PAT_BITS        = 8 * PAT_CHARS;

   // device type codes
   localparam logic [3:0] DEV_UNKNOWN    = 4'd0;
   localparam logic [3:0] DEV_PHONE      = 4'd1;
   localparam logic [3:0] DEV_TABLET     = 4'd2;
   localparam logic [3:0] DEV_LAPTOP     = 4'd3;
   localparam logic [3:0] DEV_WATCH      = 4'd4;
   localparam logic [3:0] DEV_TRACKER    = 4'd5;
   localparam logic [3:0] DEV_HEADPHONES = 4'd6;
   localparam logic [3:0] DEV_SPEAKER    = 4'd7;
   localparam logic [3:0] DEV_TV         = 4'd8;
   localparam logic [3:0] DEV_IOT        = 4'd9;
   localparam logic [3:0] DEV_GAME       = 4'd10;
   localparam logic [3:0] DEV_PRINTER    = 4'd14;

   // category indexes, highest priority first
   localparam logic [3:0] CAT_PHONE      = 4'd0;
   localparam logic [3:0] CAT_TABLET     = 4'd1;
   localparam logic [3:0] CAT_LAPTOP     = 4'd2;
   localparam logic [3:0] CAT_WATCH      = 4'd3;
   localparam logic [3:0] CAT_TRACKER    = 4'd4;
   localparam logic [3:0] CAT_HEADPHONES = 4'd5;
   localparam logic [3:0] CAT_SPEAKER    = 4'd6;
   localparam logic [3:0] CAT_TV         = 4'd7;
   localparam logic [3:0] CAT_GAME       = 4'd8;
   localparam logic [3:0] CAT_IOT        = 4'd9;
   localparam logic [3:0] CAT_PRINTER    = 4'd10;

   // address and character codes
   localparam logic [7:0] ADDR_RANDOM   = 8'd1;
   localparam int         RANDOM_BIT    = 17;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5a;
   localparam logic [7:0] CHAR_CASE_OFS = 8'h20;

   // one input word
   typedef struct packed {
      logic [7:0]  name_byte;
      logic        has_name;
      logic        first_of_record;
      logic        last_of_record;
      logic [23:0] vendor_prefix;
      logic [7:0]  address_kind;
   } item_type;

   // name pattern: text right aligned, newest char in bits 7:0
   typedef struct packed {
      logic [3:0]          cat;
      logic [3:0]          len;
      logic [PAT_BITS-1:0] text;
   } pattern_type;

   typedef struct packed {
      logic [23:0] oui;
      logic [3:0]  kind;
   } prefix_row_type;

   localparam logic [3:0] CAT_TYPE [NUM_CATS] = '{
      DEV_PHONE, DEV_TABLET, DEV_LAPTOP, DEV_WATCH, DEV_TRACKER, DEV_HEADPHONES,
      DEV_SPEAKER, DEV_TV, DEV_GAME, DEV_IOT, DEV_PRINTER
   };

   localparam pattern_type PATTERNS [NUM_PATS] = '{
      '{CAT_PHONE,      4'd6,  112'h6970686f6e65},
      '{CAT_PHONE,      4'd5,  112'h706978656c},
      '{CAT_PHONE,      4'd8,  112'h67616c6178792073},
      '{CAT_PHONE,      4'd8,  112'h67616c617879207a},
      '{CAT_PHONE,      4'd7,  112'h6f6e65706c7573},
      '{CAT_PHONE,      4'd6,  112'h7869616f6d69},
      '{CAT_PHONE,      4'd6,  112'h687561776569},
      '{CAT_PHONE,      4'd4,  112'h6f70706f},
      '{CAT_PHONE,      4'd8,  112'h6d6f746f726f6c61},
      '{CAT_TABLET,     4'd4,  112'h69706164},
      '{CAT_TABLET,     4'd10, 112'h67616c61787920746162},
      '{CAT_TABLET,     4'd6,  112'h6b696e646c65},
      '{CAT_TABLET,     4'd7,  112'h66697265206864},
      '{CAT_LAPTOP,     4'd7,  112'h6d6163626f6f6b},
      '{CAT_LAPTOP,     4'd8,  112'h7468696e6b706164},
      '{CAT_LAPTOP,     4'd7,  112'h73757266616365},
      '{CAT_LAPTOP,     4'd4,  112'h64656c6c},
      '{CAT_LAPTOP,     4'd10, 112'h6368726f6d65626f6f6b},
      '{CAT_LAPTOP,     4'd3,  112'h687020},
      '{CAT_WATCH,      4'd5,  112'h7761746368},
      '{CAT_WATCH,      4'd6,  112'h666974626974},
      '{CAT_WATCH,      4'd6,  112'h6761726d696e},
      '{CAT_WATCH,      4'd7,  112'h6d692062616e64},
      '{CAT_WATCH,      4'd10, 112'h67616c61787920666974},
      '{CAT_WATCH,      4'd7,  112'h616d617a666974},
      '{CAT_TRACKER,    4'd6,  112'h616972746167},
      '{CAT_TRACKER,    4'd4,  112'h74696c65},
      '{CAT_TRACKER,    4'd8,  112'h736d617274746167},
      '{CAT_TRACKER,    4'd7,  112'h636869706f6c6f},
      '{CAT_TRACKER,    4'd6,  112'h66696e646d79},
      '{CAT_HEADPHONES, 4'd7,  112'h616972706f6473},
      '{CAT_HEADPHONES, 4'd4,  112'h62756473},
      '{CAT_HEADPHONES, 4'd7,  112'h77682d31303030},
      '{CAT_HEADPHONES, 4'd7,  112'h77662d31303030},
      '{CAT_HEADPHONES, 4'd5,  112'h6265617473},
      '{CAT_HEADPHONES, 4'd3,  112'h6a626c},
      '{CAT_HEADPHONES, 4'd4,  112'h626f7365},
      '{CAT_HEADPHONES, 4'd9,  112'h6865616470686f6e65},
      '{CAT_HEADPHONES, 4'd7,  112'h65617262756473},
      '{CAT_HEADPHONES, 4'd4,  112'h71633335},
      '{CAT_HEADPHONES, 4'd4,  112'h71633435},
      '{CAT_HEADPHONES, 4'd6,  112'h65617266756e},
      '{CAT_SPEAKER,    4'd4,  112'h6563686f},
      '{CAT_SPEAKER,    4'd7,  112'h686f6d65706f64},
      '{CAT_SPEAKER,    4'd5,  112'h736f6e6f73},
      '{CAT_SPEAKER,    4'd11, 112'h676f6f676c6520686f6d65},
      '{CAT_SPEAKER,    4'd4,  112'h6e657374},
      '{CAT_SPEAKER,    4'd7,  112'h737065616b6572},
      '{CAT_SPEAKER,    4'd9,  112'h736f756e646c696e6b},
      '{CAT_SPEAKER,    4'd7,  112'h63686172676520},
      '{CAT_SPEAKER,    4'd5,  112'h666c697020},
      '{CAT_SPEAKER,    4'd3,  112'h756520},
      '{CAT_TV,         4'd4,  112'h5b74765d},
      '{CAT_TV,         4'd4,  112'h726f6b75},
      '{CAT_TV,         4'd10, 112'h6368726f6d6563617374},
      '{CAT_TV,         4'd7,  112'h66697265207476},
      '{CAT_TV,         4'd8,  112'h6170706c65207476},
      '{CAT_TV,         4'd10, 112'h73616d73756e67207476},
      '{CAT_TV,         4'd5,  112'h6c67207476},
      '{CAT_GAME,       4'd4,  112'h78626f78},
      '{CAT_GAME,       4'd9,  112'h6475616c73656e7365},
      '{CAT_GAME,       4'd9,  112'h6475616c73686f636b},
      '{CAT_GAME,       4'd7,  112'h6a6f792d636f6e},
      '{CAT_GAME,       4'd14, 112'h70726f20636f6e74726f6c6c6572},
      '{CAT_GAME,       4'd6,  112'h737769746368},
      '{CAT_IOT,        4'd3,  112'h687565},
      '{CAT_IOT,        4'd4,  112'h6c696678},
      '{CAT_IOT,        4'd4,  112'h72696e67},
      '{CAT_IOT,        4'd4,  112'h77797a65},
      '{CAT_IOT,        4'd5,  112'h6573703332},
      '{CAT_IOT,        4'd6,  112'h7368656c6c79},
      '{CAT_IOT,        4'd4,  112'h74757961},
      '{CAT_IOT,        4'd7,  112'h7461736d6f7461},
      '{CAT_PRINTER,    4'd7,  112'h7072696e746572},
      '{CAT_PRINTER,    4'd4,  112'h656e7679},
      '{CAT_PRINTER,    4'd9,  112'h6f66666963656a6574},
      '{CAT_PRINTER,    4'd8,  112'h6c617365726a6574}
   };

   localparam prefix_row_type PREFIX_TABLE [NUM_PREFIX_ROWS] = '{
      '{24'h4C1DBE, DEV_PHONE},      '{24'hDCCF96, DEV_PHONE},
      '{24'h3CE072, DEV_PHONE},      '{24'h286C07, DEV_PHONE},
      '{24'hA4D18C, DEV_PHONE},      '{24'h68FEF7, DEV_PHONE},
      '{24'hF01898, DEV_PHONE},      '{24'hEC1F72, DEV_PHONE},
      '{24'h8425DB, DEV_PHONE},      '{24'h002637, DEV_PHONE},
      '{24'hC0BDC8, DEV_PHONE},      '{24'hF4F5D8, DEV_PHONE},
      '{24'hF4F5E8, DEV_PHONE},      '{24'h546009, DEV_SPEAKER},
      '{24'h74C246, DEV_SPEAKER},    '{24'hFC65DE, DEV_SPEAKER},
      '{24'hA002DC, DEV_SPEAKER},    '{24'hF013C3, DEV_TRACKER},
      '{24'hC8FF28, DEV_WATCH},      '{24'h0452C7, DEV_HEADPHONES},
      '{24'h2C41A1, DEV_HEADPHONES}, '{24'hAC9B0A, DEV_HEADPHONES},
      '{24'h045D4B, DEV_HEADPHONES}, '{24'h001DDF, DEV_SPEAKER},
      '{24'h3C58C2, DEV_LAPTOP},     '{24'h3413E8, DEV_LAPTOP},
      '{24'h7CB27D, DEV_LAPTOP},     '{24'h281878, DEV_LAPTOP},
      '{24'h7C1E52, DEV_GAME},       '{24'h240AC4, DEV_IOT},
      '{24'h2462AB, DEV_IOT},        '{24'h30AEA4, DEV_IOT},
      '{24'hB827EB, DEV_IOT},        '{24'hD83ADD, DEV_IOT},
      '{24'h001788, DEV_IOT},        '{24'h343DC4, DEV_IOT}
   };

   // ascii upper to lower, other codes unchanged
   function automatic logic [7:0] to_lower(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         r = b + CHAR_CASE_OFS;
      end
      return r;
   endfunction

   // compare every pattern against the newest window bytes
   function automatic logic [NUM_CATS-1:0] match_hits(input logic [PAT_BITS-1:0] tail);
      logic [NUM_CATS-1:0] hits;
      logic                ok;
      hits = '0;
      for (int p = 0; p < NUM_PATS; p++) begin
         ok = (PATTERNS[p].len != 4'd0) && (int'(PATTERNS[p].len) <= WINDOW_LEN);
         for (int k = 0; k < PAT_CHARS; k++) begin
            if (4'(k) < PATTERNS[p].len && tail[8*k +: 8] != PATTERNS[p].text[8*k +: 8]) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            hits[PATTERNS[p].cat] = 1'b1;
         end
      end
      return hits;
   endfunction

   // vendor prefix search, first matching row wins
   function automatic logic [3:0] lookup_prefix(input logic [23:0] oui);
      logic [3:0] kind;
      kind = DEV_UNKNOWN;
      for (int i = NUM_PREFIX_ROWS - 1; i >= 0; i--) begin
         if (i < PREFIX_ENTRIES && PREFIX_TABLE[i].oui == oui) begin
            kind = PREFIX_TABLE[i].kind;
         end
      end
      return kind;
   endfunction

   // first hit category, else prefix type, else random guess
   function automatic logic [3:0] pick_type(input logic [NUM_CATS-1:0] hits,
                                            input logic [3:0]          prefix_kind,
                                            input logic                random_guess);
      logic [3:0] t;
      t = DEV_UNKNOWN;
      for (int i = NUM_CATS - 1; i >= 0; i--) begin
         if (hits[i]) begin
            t = CAT_TYPE[i];
         end
      end
      if (t == DEV_UNKNOWN) begin
         t = prefix_kind;
      end
      if (t == DEV_UNKNOWN && random_guess) begin
         t = DEV_PHONE;
      end
      return t;
   endfunction

endpackage

`default_nettype wire

@@ rtl/rdnc_record.sv @@
// ----------------------------------------------------------------------------
// rdnc_record
// per-record state: name window, category hit flags, prefix type and
// random address guess; gives the device type that the current word leaves
// ----------------------------------------------------------------------------
`default_nettype none

module rdnc_record (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire rdnc_pkg::item_type item,
   output logic [3:0]             device_type
);

   logic [7:0]                   char_window_ff [rdnc_pkg::WINDOW_LEN];
   logic [7:0]                   char_window_in [rdnc_pkg::WINDOW_LEN];
   logic [7:0]                   window_base    [rdnc_pkg::WINDOW_LEN];
   logic [rdnc_pkg::NUM_CATS-1:0] category_hits_ff, category_hits_in, hits_base;
   logic [3:0]                   prefix_type_ff, prefix_type_in;
   logic                         random_guess_ff, random_guess_in;
   logic [rdnc_pkg::PAT_BITS-1:0] tail;

   // start of record wipes window and hits and samples the address
   always_comb begin
      for (int k = 0; k < rdnc_pkg::WINDOW_LEN; k++) begin
         window_base[k] = item.first_of_record ? 8'h00 : char_window_ff[k];
      end
      hits_base = item.first_of_record ? '0 : category_hits_ff;
      if (item.first_of_record) begin
         prefix_type_in  = rdnc_pkg::lookup_prefix(item.vendor_prefix);
         random_guess_in = (item.address_kind == rdnc_pkg::ADDR_RANDOM) ||
                           item.vendor_prefix[rdnc_pkg::RANDOM_BIT];
      end else begin
         prefix_type_in  = prefix_type_ff;
         random_guess_in = random_guess_ff;
      end
   end

   // shift in the lowercased char and match against the newest bytes
   always_comb begin
      char_window_in = window_base;
      if (item.has_name) begin
         char_window_in[0] = rdnc_pkg::to_lower(item.name_byte);
         for (int k = 1; k < rdnc_pkg::WINDOW_LEN; k++) begin
            char_window_in[k] = window_base[k-1];
         end
      end
      for (int k = 0; k < rdnc_pkg::PAT_CHARS; k++) begin
         tail[8*k +: 8] = char_window_in[k];
      end
      category_hits_in = hits_base;
      if (item.has_name) begin
         category_hits_in = hits_base | rdnc_pkg::match_hits(tail);
      end
   end

   // result for this word if it closes the record
   assign device_type = rdnc_pkg::pick_type(category_hits_in, prefix_type_in, random_guess_in);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rdnc_pkg::WINDOW_LEN; k++) begin
            char_window_ff[k] <= 8'h00;
         end
         category_hits_ff <= '0;
         prefix_type_ff   <= rdnc_pkg::DEV_UNKNOWN;
         random_guess_ff  <= 1'b0;
      end else if (step) begin
         char_window_ff   <= char_window_in;
         category_hits_ff <= category_hits_in;
         prefix_type_ff   <= prefix_type_in;
         random_guess_ff  <= random_guess_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/radio_device_name_classifier.sv @@
// ----------------------------------------------------------------------------
// radio_device_name_classifier
// classifies scan records by advertised name, vendor prefix and address type
// ----------------------------------------------------------------------------
//  channel   dir  handshake            word
//  req_      in   req_valid/req_stall  one name byte plus record markers
//  rsp_      out  rsp_valid/rsp_stall  device type, one per closing word
//
//  one word per clock while req_stall is low; a word goes input register -> result
//  register, so rsp_valid rises once its closing word enters the result register.
//  the window compare and hit update run once per cycle on the input register while req_stall is low.
//  synchronous active-high reset empties both stages and the record state.
//  req_stall rises only when a closing word waits on a full, stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_device_name_classifier (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_name_byte,
   input  wire logic        req_has_name,
   input  wire logic        req_first_of_record,
   input  wire logic        req_last_of_record,
   input  wire logic [23:0] req_vendor_prefix,
   input  wire logic [7:0]  req_address_kind,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_device_type
);

`include "assert_macros.svh"

   logic               s1_valid_ff, s1_valid_in;
   rdnc_pkg::item_type s1_item_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_device_type_ff;
   logic [3:0]         next_type;
   logic               rsp_free, s1_go, req_accept;

   // flow control between the two stages
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_go      = s1_valid_ff && (!s1_item_ff.last_of_record || rsp_free);
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = (s1_go && s1_item_ff.last_of_record) ? 1'b1 :
                         (rsp_stall ? rsp_valid_ff : 1'b0);

   // record state and matching
   rdnc_record u_record (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_go),
      .item        (s1_item_ff),
      .device_type (next_type)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_item_ff.name_byte       <= req_name_byte;
         s1_item_ff.has_name        <= req_has_name;
         s1_item_ff.first_of_record <= req_first_of_record;
         s1_item_ff.last_of_record  <= req_last_of_record;
         s1_item_ff.vendor_prefix   <= req_vendor_prefix;
         s1_item_ff.address_kind    <= req_address_kind;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_go && s1_item_ff.last_of_record) begin
         rsp_device_type_ff <= next_type;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_device_type = rsp_device_type_ff;

   // checks
   `RDNC_ASSERT(a_close_gives_result,
      (s1_go && s1_item_ff.last_of_record) |=> rsp_valid_ff,
      "closing word did not produce a result")
   `RDNC_ASSERT(a_result_has_source,
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |->
         $past(s1_go && s1_item_ff.last_of_record),
      "result appeared without a closing word")
   `RDNC_ASSERT(a_stall_only_when_blocked,
      req_stall |-> (s1_valid_ff && s1_item_ff.last_of_record && rsp_valid_ff && rsp_stall),
      "input stalled without a blocked result")
   `RDNC_ASSERT_ALWAYS(a_reset_empties,
      $past(reset) |-> (!rsp_valid_ff && !s1_valid_ff),
      "pipeline not empty after reset")

endmodule

`default_nettype wire

@@ tb/sv/radio_device_name_classifier_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_device_name_classifier_tb
// Sends scan records one name byte per word, with random gaps on the sender
// and random stalls on the receiver. A model of the classifier with its own
// pattern and vendor lists predicts the device type of each closed record,
// and every result word is checked in order against those predictions.
// ----------------------------------------------------------------------------

module radio_device_name_classifier_tb;

   import rdnc_pkg::*;

   // pattern list: length, then text with the newest char in bits 7:0
   localparam int NUM_NAME_PATS = 77;
   localparam int LONGEST_PAT   = 63;
   localparam int OUI_COUNT     = 36;

   localparam logic [115:0] NAME_PATS [NUM_NAME_PATS] = '{
      {4'd6,  112'h6970686f6e65},       {4'd5,  112'h706978656c},
      {4'd8,  112'h67616c6178792073},   {4'd8,  112'h67616c617879207a},
      {4'd7,  112'h6f6e65706c7573},     {4'd6,  112'h7869616f6d69},
      {4'd6,  112'h687561776569},       {4'd4,  112'h6f70706f},
      {4'd8,  112'h6d6f746f726f6c61},
      {4'd4,  112'h69706164},           {4'd10, 112'h67616c61787920746162},
      {4'd6,  112'h6b696e646c65},       {4'd7,  112'h66697265206864},
      {4'd7,  112'h6d6163626f6f6b},     {4'd8,  112'h7468696e6b706164},
      {4'd7,  112'h73757266616365},     {4'd4,  112'h64656c6c},
      {4'd10, 112'h6368726f6d65626f6f6b}, {4'd3,  112'h687020},
      {4'd5,  112'h7761746368},         {4'd6,  112'h666974626974},
      {4'd6,  112'h6761726d696e},       {4'd7,  112'h6d692062616e64},
      {4'd10, 112'h67616c61787920666974}, {4'd7,  112'h616d617a666974},
      {4'd6,  112'h616972746167},       {4'd4,  112'h74696c65},
      {4'd8,  112'h736d617274746167},   {4'd7,  112'h636869706f6c6f},
      {4'd6,  112'h66696e646d79},
      {4'd7,  112'h616972706f6473},     {4'd4,  112'h62756473},
      {4'd7,  112'h77682d31303030},     {4'd7,  112'h77662d31303030},
      {4'd5,  112'h6265617473},         {4'd3,  112'h6a626c},
      {4'd4,  112'h626f7365},           {4'd9,  112'h6865616470686f6e65},
      {4'd7,  112'h65617262756473},     {4'd4,  112'h71633335},
      {4'd4,  112'h71633435},           {4'd6,  112'h65617266756e},
      {4'd4,  112'h6563686f},           {4'd7,  112'h686f6d65706f64},
      {4'd5,  112'h736f6e6f73},         {4'd11, 112'h676f6f676c6520686f6d65},
      {4'd4,  112'h6e657374},           {4'd7,  112'h737065616b6572},
      {4'd9,  112'h736f756e646c696e6b}, {4'd7,  112'h63686172676520},
      {4'd5,  112'h666c697020},         {4'd3,  112'h756520},
      {4'd4,  112'h5b74765d},           {4'd4,  112'h726f6b75},
      {4'd10, 112'h6368726f6d6563617374}, {4'd7,  112'h66697265207476},
      {4'd8,  112'h6170706c65207476},   {4'd10, 112'h73616d73756e67207476},
      {4'd5,  112'h6c67207476},
      {4'd4,  112'h78626f78},           {4'd9,  112'h6475616c73656e7365},
      {4'd9,  112'h6475616c73686f636b}, {4'd7,  112'h6a6f792d636f6e},
      {4'd14, 112'h70726f20636f6e74726f6c6c6572}, {4'd6,  112'h737769746368},
      {4'd3,  112'h687565},             {4'd4,  112'h6c696678},
      {4'd4,  112'h72696e67},           {4'd4,  112'h77797a65},
      {4'd5,  112'h6573703332},         {4'd6,  112'h7368656c6c79},
      {4'd4,  112'h74757961},           {4'd7,  112'h7461736d6f7461},
      {4'd7,  112'h7072696e746572},     {4'd4,  112'h656e7679},
      {4'd9,  112'h6f66666963656a6574}, {4'd8,  112'h6c617365726a6574}
   };

   // first pattern of each category, priority order, with an end marker
   localparam int CAT_START [NUM_CATS+1] = '{0, 9, 13, 19, 25, 30, 42, 52, 59, 65, 73, 77};

   localparam logic [3:0] CAT_DEVICE [NUM_CATS] = '{
      DEV_PHONE, DEV_TABLET, DEV_LAPTOP, DEV_WATCH, DEV_TRACKER, DEV_HEADPHONES,
      DEV_SPEAKER, DEV_TV, DEV_GAME, DEV_IOT, DEV_PRINTER
   };

   // vendor prefix rows: prefix, device type
   localparam logic [27:0] OUI_ROWS [OUI_COUNT] = '{
      {24'h4C1DBE, DEV_PHONE},      {24'hDCCF96, DEV_PHONE},
      {24'h3CE072, DEV_PHONE},      {24'h286C07, DEV_PHONE},
      {24'hA4D18C, DEV_PHONE},      {24'h68FEF7, DEV_PHONE},
      {24'hF01898, DEV_PHONE},      {24'hEC1F72, DEV_PHONE},
      {24'h8425DB, DEV_PHONE},      {24'h002637, DEV_PHONE},
      {24'hC0BDC8, DEV_PHONE},      {24'hF4F5D8, DEV_PHONE},
      {24'hF4F5E8, DEV_PHONE},      {24'h546009, DEV_SPEAKER},
      {24'h74C246, DEV_SPEAKER},    {24'hFC65DE, DEV_SPEAKER},
      {24'hA002DC, DEV_SPEAKER},    {24'hF013C3, DEV_TRACKER},
      {24'hC8FF28, DEV_WATCH},      {24'h0452C7, DEV_HEADPHONES},
      {24'h2C41A1, DEV_HEADPHONES}, {24'hAC9B0A, DEV_HEADPHONES},
      {24'h045D4B, DEV_HEADPHONES}, {24'h001DDF, DEV_SPEAKER},
      {24'h3C58C2, DEV_LAPTOP},     {24'h3413E8, DEV_LAPTOP},
      {24'h7CB27D, DEV_LAPTOP},     {24'h281878, DEV_LAPTOP},
      {24'h7C1E52, DEV_GAME},       {24'h240AC4, DEV_IOT},
      {24'h2462AB, DEV_IOT},        {24'h30AEA4, DEV_IOT},
      {24'hB827EB, DEV_IOT},        {24'hD83ADD, DEV_IOT},
      {24'h001788, DEV_IOT},        {24'h343DC4, DEV_IOT}
   };

   // filler character codes
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DASH    = 8'h2d;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam int RANDOM_WORDS = 700;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_name_byte;
   logic        req_has_name;
   logic        req_first_of_record;
   logic        req_last_of_record;
   logic [23:0] req_vendor_prefix;
   logic [7:0]  req_address_kind;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_device_type;

   // classifier model state
   logic [7:0]          name_win [WINDOW_LEN];
   logic [NUM_CATS-1:0] seen_cats;
   logic [3:0]          vendor_kind;
   bit                  rand_addr;

   logic [3:0] expected_types [$];
   int         mismatch_count;
   int         words_sent;
   bit         quiet_send;
   bit         quiet_recv;

   radio_device_name_classifier DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_name_byte       (req_name_byte),
      .req_has_name        (req_has_name),
      .req_first_of_record (req_first_of_record),
      .req_last_of_record  (req_last_of_record),
      .req_vendor_prefix   (req_vendor_prefix),
      .req_address_kind    (req_address_kind),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_device_type     (rsp_device_type)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one line per mismatch; -1 stands for no value
   task automatic report_mismatch(input int got, input int want);
      mismatch_count++;
      if (want < 0) begin
         $display("mismatch at %0t: device type %0d with no word expected", $time, got);
      end else if (got < 0) begin
         $display("mismatch at %0t: device type %0d expected but never came", $time, want);
      end else begin
         $display("mismatch at %0t: device type %0d, expected %0d", $time, got, want);
      end
   endtask

   // newest window bytes against one pattern
   function automatic bit tail_matches(input logic [115:0] pat);
      int len;
      len = int'(pat[115:112]);
      if (len == 0 || len > WINDOW_LEN) begin
         return 1'b0;
      end
      for (int k = 0; k < len; k++) begin
         if (name_win[k] != pat[8*k +: 8]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // first vendor row that matches
   function automatic logic [3:0] find_vendor(input logic [23:0] oui);
      for (int i = 0; i < OUI_COUNT && i < PREFIX_ENTRIES; i++) begin
         if (OUI_ROWS[i][27:4] == oui) begin
            return OUI_ROWS[i][3:0];
         end
      end
      return DEV_UNKNOWN;
   endfunction

   // update the model with one accepted word, queue a type on a closing word
   function automatic void classify_word(input item_type w);
      logic [7:0] b;
      logic [3:0] dev;
      if (w.first_of_record) begin
         for (int k = 0; k < WINDOW_LEN; k++) begin
            name_win[k] = 8'h00;
         end
         seen_cats   = '0;
         vendor_kind = find_vendor(w.vendor_prefix);
         rand_addr   = (w.address_kind == ADDR_RANDOM) || w.vendor_prefix[RANDOM_BIT];
      end
      if (w.has_name) begin
         b = w.name_byte;
         if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            b = b + CHAR_CASE_OFS;
         end
         for (int k = WINDOW_LEN - 1; k > 0; k--) begin
            name_win[k] = name_win[k-1];
         end
         name_win[0] = b;
         for (int c = 0; c < NUM_CATS; c++) begin
            for (int p = CAT_START[c]; p < CAT_START[c+1]; p++) begin
               if (tail_matches(NAME_PATS[p])) begin
                  seen_cats[c] = 1'b1;
               end
            end
         end
      end
      if (w.last_of_record) begin
         dev = DEV_UNKNOWN;
         for (int c = NUM_CATS - 1; c >= 0; c--) begin
            if (seen_cats[c]) begin
               dev = CAT_DEVICE[c];
            end
         end
         if (dev == DEV_UNKNOWN) begin
            dev = vendor_kind;
         end
         if (dev == DEV_UNKNOWN && rand_addr) begin
            dev = DEV_PHONE;
         end
         expected_types.push_back(dev);
      end
   endfunction

   function automatic item_type make_word(input logic [7:0] b, input bit named,
                                          input bit first, input bit last,
                                          input logic [23:0] oui, input logic [7:0] akind);
      item_type w;
      w.name_byte       = b;
      w.has_name        = named;
      w.first_of_record = first;
      w.last_of_record  = last;
      w.vendor_prefix   = oui;
      w.address_kind    = akind;
      return w;
   endfunction

   // send one word after a random gap, then update the model
   task automatic send_word(input item_type w);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_name_byte       = w.name_byte;
      req_has_name        = w.has_name;
      req_first_of_record = w.first_of_record;
      req_last_of_record  = w.last_of_record;
      req_vendor_prefix   = w.vendor_prefix;
      req_address_kind    = w.address_kind;
      req_valid           = 1'b1;
      do @(posedge clock); while (req_stall);
      if (w.has_name || w.first_of_record || w.last_of_record) begin
         words_sent++;
      end
      classify_word(w);
   endtask

   // whole record from packed text, first char in the top used byte
   task automatic send_name(input logic [111:0] text, input int len, input bit first,
                            input logic [23:0] oui, input logic [7:0] akind,
                            input bit named);
      for (int k = len - 1; k >= 0; k--) begin
         send_word(make_word(text[8*k +: 8], named, first && k == len - 1, k == 0,
                             oui, akind));
      end
   endtask

   function automatic logic [7:0] mixed_case(input logic [7:0] c);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z && $urandom_range(0, 1) == 1) begin
         return c - CHAR_CASE_OFS;
      end
      return c;
   endfunction

   function automatic logic [7:0] filler_char();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) begin
         return mixed_case(8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z)));
      end else if (r == 7) begin
         return CHAR_SPACE;
      end else if (r == 8) begin
         return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
      end
      return CHAR_DASH;
   endfunction

   // words ahead of any first marker run on the state left by reset
   task automatic test_before_first_marker();
      send_name(112'h685565, 3, 1'b0, 24'h240AC4, 8'h00, 1'b1);
   endtask

   // first and last on one word, field extremes
   task automatic test_single_word_records();
      send_word(make_word(8'hFF, 1'b1, 1'b1, 1'b1, 24'hFFFFFF, 8'hFF));
      send_word(make_word(8'h00, 1'b0, 1'b1, 1'b1, 24'h000000, 8'h00));
      send_word(make_word(8'h00, 1'b1, 1'b1, 1'b1, 24'h000000, ADDR_RANDOM));
   endtask

   // bytes without has_name set match nothing, prefix decides
   task automatic test_nameless_record();
      send_name(112'h6a626c, 3, 1'b1, 24'hF013C3, 8'h00, 1'b0);
   endtask

   // zero byte inside a pattern breaks the match
   task automatic test_zero_byte_split();
      send_name(112'h7469006c65, 5, 1'b1, 24'h000000, ADDR_RANDOM, 1'b1);
   endtask

   // upper case folding, and two categories in one name
   task automatic test_case_and_priority();
      send_name(112'h54494c45, 4, 1'b1, 24'h343DC4, 8'h00, 1'b1);
      send_name(112'h68756520, 4, 1'b1, 24'h4C1DBE, 8'h02, 1'b1);
   endtask

   // one record: mostly well formed with pattern text, some pure noise
   task automatic send_random_record();
      logic [7:0]   chars [$];
      logic [115:0] pat;
      logic [23:0]  oui;
      logic [7:0]   akind;
      int           n;
      int           npat;
      bit           named;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 12);
         repeat (n) begin
            send_word(make_word(8'($urandom), 1'($urandom), $urandom_range(0, 4) == 0,
                                $urandom_range(0, 4) == 0, 24'($urandom), 8'($urandom)));
         end
         return;
      end
      case ($urandom_range(0, 4))
         0, 1: oui = OUI_ROWS[$urandom_range(0, OUI_COUNT - 1)][27:4];
         2: oui = 24'($urandom) & ~(24'd1 << RANDOM_BIT);
         default: oui = 24'($urandom);
      endcase
      akind = ($urandom_range(0, 4) == 0) ? ADDR_RANDOM : 8'($urandom);
      named = $urandom_range(0, 9) != 0;
      npat  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2);
      repeat ($urandom_range(0, 6)) chars.push_back(filler_char());
      repeat (npat) begin
         pat = NAME_PATS[($urandom_range(0, 4) == 0) ? LONGEST_PAT
                                                     : $urandom_range(0, NUM_NAME_PATS - 1)];
         for (int k = int'(pat[115:112]) - 1; k >= 0; k--) begin
            chars.push_back(mixed_case(pat[8*k +: 8]));
         end
      end
      repeat ($urandom_range(0, 3)) chars.push_back(filler_char());
      if (chars.size() == 0) begin
         chars.push_back(filler_char());
      end
      foreach (chars[i]) begin
         send_word(make_word(chars[i], named && $urandom_range(0, 19) != 0, i == 0,
                             i == chars.size() - 1, oui, akind));
      end
   endtask

   task automatic test_random_records();
      int start;
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         // switch gap-free stretches on and off now and then
         if ($urandom_range(0, 7) == 0) begin
            quiet_send = $urandom_range(0, 2) == 0;
            quiet_recv = $urandom_range(0, 2) == 0;
         end
         send_random_record();
      end
   endtask

   // result side: random hold before each word, then check it
   initial begin
      int         hold;
      logic [3:0] want;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         hold = quiet_recv ? 0 : $urandom_range(0, 18);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall = 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         if (expected_types.size() == 0) begin
            report_mismatch(int'(rsp_device_type), -1);
         end else begin
            want = expected_types.pop_front();
            if (rsp_device_type !== want) begin
               report_mismatch(int'(rsp_device_type), int'(want));
            end
         end
      end
   end

   // main sequence
   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_name_byte       = 8'h00;
      req_has_name        = 1'b0;
      req_first_of_record = 1'b0;
      req_last_of_record  = 1'b0;
      req_vendor_prefix   = 24'h000000;
      req_address_kind    = 8'h00;
      mismatch_count      = 0;
      words_sent          = 0;
      quiet_send          = 1'b0;
      quiet_recv          = 1'b0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
         name_win[k] = 8'h00;
      end
      seen_cats   = '0;
      vendor_kind = DEV_UNKNOWN;
      rand_addr   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_before_first_marker();
      test_single_word_records();
      test_nameless_record();
      test_zero_byte_split();
      test_case_and_priority();
      test_random_records();

      @(negedge clock);
      req_valid = 1'b0;

      // drain, then wait for any stray word
      repeat (2000) begin
         if (expected_types.size() != 0) begin
            @(posedge clock);
         end
      end
      repeat (16) @(posedge clock);
      while (expected_types.size() != 0) begin
         report_mismatch(-1, int'(expected_types.pop_front()));
      end
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
